[rtl/btff_pkg.sv]
package btff_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int TAG_W          = 18;
  localparam int ROUND_W        = 17;
  localparam int REQ_W          = 16;
  localparam int ADDR_W         = 16;
  localparam int MIN_SPLIT      = 16;
  localparam logic [ROUND_W-1:0] ROUND_RESET = 17'd512;

  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  // datapath commands, one per controller cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WALK_RD,
    OP_WALK_EVAL,
    OP_SPL_LO,
    OP_SPL_FT,
    OP_SPL_HD,
    OP_RD_HDR,
    OP_LD_TAG,
    OP_GROW,
    OP_MRK_FT,
    OP_MRK_HD,
    OP_FREE_RD,
    OP_FREE_CLR,
    OP_FREE_FT,
    OP_RD_PFT,
    OP_RD_NXT,
    OP_RD_PHD,
    OP_MRG_PREV,
    OP_MRG_NEXT,
    OP_WR_FH,
    OP_WR_FF
  } op_e;

  typedef struct packed {
    logic walk_go;
    logic fit;
    logic zero_tag;
    logic split;
    logic oom;
    logic bad_free;
  } status_t;

endpackage

[rtl/btff_ctrl.sv]
module btff_ctrl
  import btff_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    opcode_i,
  input  status_t st_i,
  output op_e     op_o,
  output logic    busy,
  output logic    done_o
);

  typedef enum logic [22:0] {
    ST_IDLE  = 23'd1,
    ST_WCHK  = 23'd2,
    ST_WEVAL = 23'd4,
    ST_FOUND = 23'd8,
    ST_SPL1  = 23'd16,
    ST_SPL2  = 23'd32,
    ST_SPL3  = 23'd64,
    ST_RDH   = 23'd128,
    ST_LDT   = 23'd256,
    ST_GROW  = 23'd512,
    ST_MRK1  = 23'd1024,
    ST_MRK2  = 23'd2048,
    ST_FCHK  = 23'd4096,
    ST_F1    = 23'd8192,
    ST_F2    = 23'd16384,
    ST_F3    = 23'd32768,
    ST_F4    = 23'd65536,
    ST_F5    = 23'd131072,
    ST_F6    = 23'd262144,
    ST_F7    = 23'd524288,
    ST_F8    = 23'd1048576,
    ST_F9    = 23'd2097152,
    ST_DONE  = 23'd4194304
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_o    = OP_LOAD;
          state_d = (opcode_i == OPC_FREE) ? ST_FCHK : ST_WCHK;
        end
      end
      ST_WCHK: begin
        op_o    = OP_WALK_RD;
        state_d = st_i.walk_go ? ST_WEVAL : ST_GROW;
      end
      ST_WEVAL: begin
        op_o = OP_WALK_EVAL;
        if (st_i.fit) state_d = ST_FOUND;
        else if (st_i.zero_tag) state_d = ST_GROW;
        else state_d = ST_WCHK;
      end
      ST_FOUND: state_d = st_i.split ? ST_SPL1 : ST_MRK1;
      ST_SPL1: begin
        op_o    = OP_SPL_LO;
        state_d = ST_SPL2;
      end
      ST_SPL2: begin
        op_o    = OP_SPL_FT;
        state_d = ST_SPL3;
      end
      ST_SPL3: begin
        op_o    = OP_SPL_HD;
        state_d = ST_RDH;
      end
      ST_RDH: begin
        op_o    = OP_RD_HDR;
        state_d = ST_LDT;
      end
      ST_LDT: begin
        op_o    = OP_LD_TAG;
        state_d = ST_MRK1;
      end
      ST_GROW: begin
        op_o    = OP_GROW;
        state_d = st_i.oom ? ST_DONE : ST_MRK1;
      end
      ST_MRK1: begin
        op_o    = OP_MRK_FT;
        state_d = ST_MRK2;
      end
      ST_MRK2: begin
        op_o    = OP_MRK_HD;
        state_d = ST_DONE;
      end
      ST_FCHK: begin
        op_o    = OP_FREE_RD;
        state_d = st_i.bad_free ? ST_DONE : ST_F1;
      end
      ST_F1: begin
        op_o    = OP_FREE_CLR;
        state_d = ST_F2;
      end
      ST_F2: begin
        op_o    = OP_FREE_FT;
        state_d = ST_F3;
      end
      ST_F3: begin
        op_o    = OP_RD_PFT;
        state_d = ST_F4;
      end
      ST_F4: begin
        op_o    = OP_RD_NXT;
        state_d = ST_F5;
      end
      ST_F5: begin
        op_o    = OP_RD_PHD;
        state_d = ST_F6;
      end
      ST_F6: begin
        op_o    = OP_MRG_PREV;
        state_d = ST_F7;
      end
      ST_F7: begin
        op_o    = OP_MRG_NEXT;
        state_d = ST_F8;
      end
      ST_F8: begin
        op_o    = OP_WR_FH;
        state_d = ST_F9;
      end
      ST_F9: begin
        op_o    = OP_WR_FF;
        state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

[rtl/btff_dp.sv]
module btff_dp
  import btff_pkg::*;
#(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  op_e                op_i,
  input  logic [REQ_W-1:0]   request_size_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  input  logic               cfg_we_i,
  input  logic [ROUND_W-1:0] cfg_wdata_i,
  output status_t            st_o,
  output logic [ADDR_W-1:0]  payload_address_o,
  output logic               status_o
);

  localparam int AW        = $clog2(HEAP_BYTES);
  localparam int WW        = AW - 3;
  localparam int TAG_WORDS = HEAP_BYTES / 8;
  localparam int XW        = ((AW > TAG_W) ? AW : TAG_W) + 2;
  localparam logic [XW-1:0] HEAP_X  = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] EIGHT_X = XW'(8);
  localparam logic [WW:0]   WORDS_C = (WW+1)'(TAG_WORDS);

  logic [TAG_W-1:0] mem [TAG_WORDS];
  logic [TAG_W-1:0] rdata_q;

  logic [ROUND_W-1:0] round_limit_q;
  logic [AW:0]        top_q;
  logic [XW-1:0]      a_q, h_q, size_q, fh_q, ff_q, ph_q, nh_q, nf_q;
  logic [WW:0]        steps_q;
  logic [TAG_W-1:0]   t_q, blk_q, ntag_q;
  logic [ADDR_W-1:0]  p_q;

  logic               mem_we;
  logic [XW-1:0]      mem_addr;
  logic [TAG_W-1:0]   mem_wdata;

  logic [TAG_W-1:0]   tclr;
  logic [XW-1:0]      tclr_x, top_x, blk_x, t_x, p_x;
  logic [REQ_W-1:0]   smear;
  logic [TAG_W-1:0]   pow2, blk_d;
  logic               has_prev, has_next;

  // next power of two by bit smearing of req-1, or req itself above the round limit
  always_comb begin
    smear = request_size_i - REQ_W'(1);
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    if (request_size_i <= REQ_W'(1)) pow2 = TAG_W'(1);
    else pow2 = TAG_W'(smear) + TAG_W'(1);
    if (ROUND_W'(request_size_i) > round_limit_q) pow2 = TAG_W'(request_size_i);
    blk_d = (pow2 + TAG_W'(23)) & ~TAG_W'(7);
  end

  assign tclr     = {rdata_q[TAG_W-1:1], 1'b0};
  assign tclr_x   = XW'(tclr);
  assign top_x    = XW'(top_q);
  assign blk_x    = XW'(blk_q);
  assign t_x      = XW'(t_q);
  assign p_x      = XW'(p_q);
  assign has_prev = (h_q != '0);
  assign has_next = (nh_q < top_x);

  assign st_o.walk_go  = (a_q < top_x) && (steps_q < WORDS_C);
  assign st_o.fit      = !rdata_q[0] && (rdata_q >= blk_q);
  assign st_o.zero_tag = (tclr == '0);
  assign st_o.split    = ((t_q - blk_q) >= TAG_W'(MIN_SPLIT));
  assign st_o.oom      = (top_x + blk_x) > HEAP_X;
  assign st_o.bad_free = (p_q < ADDR_W'(8)) || (p_q[2:0] != 3'd0) ||
                         ((p_x - EIGHT_X) >= top_x);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = a_q;
    mem_wdata = t_q;
    case (op_i)
      OP_WALK_RD: mem_addr = a_q;
      OP_SPL_LO: begin
        mem_we    = 1'b1;
        mem_addr  = h_q + blk_x;
        mem_wdata = t_q - blk_q;
      end
      OP_SPL_FT: begin
        mem_we    = 1'b1;
        mem_addr  = h_q + t_x - EIGHT_X;
        mem_wdata = t_q - blk_q;
      end
      OP_SPL_HD: begin
        mem_we    = 1'b1;
        mem_addr  = h_q;
        mem_wdata = blk_q;
      end
      OP_RD_HDR: mem_addr = h_q;
      OP_GROW: begin
        mem_we    = !st_o.oom;
        mem_addr  = top_x;
        mem_wdata = blk_q;
      end
      OP_MRK_FT: begin
        mem_we    = 1'b1;
        mem_addr  = h_q + t_x - EIGHT_X;
        mem_wdata = t_q | TAG_W'(1);
      end
      OP_MRK_HD: begin
        mem_we    = 1'b1;
        mem_addr  = h_q;
        mem_wdata = t_q | TAG_W'(1);
      end
      OP_FREE_RD: mem_addr = p_x - EIGHT_X;
      OP_FREE_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = h_q;
        mem_wdata = tclr;
      end
      OP_FREE_FT: begin
        mem_we    = 1'b1;
        mem_addr  = h_q + size_q - EIGHT_X;
        mem_wdata = size_q[TAG_W-1:0];
      end
      OP_RD_PFT: mem_addr = h_q - EIGHT_X;
      OP_RD_NXT: mem_addr = nh_q;
      OP_RD_PHD: mem_addr = ph_q;
      OP_WR_FH: begin
        mem_we    = 1'b1;
        mem_addr  = fh_q;
        mem_wdata = size_q[TAG_W-1:0];
      end
      OP_WR_FF: begin
        mem_we    = 1'b1;
        mem_addr  = ff_q;
        mem_wdata = size_q[TAG_W-1:0];
      end
      default: mem_we = 1'b0;
    endcase
  end

  // tag store, word addressed, addresses wrap
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr[AW-1:3]] <= mem_wdata;
    rdata_q <= mem[mem_addr[AW-1:3]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_limit_q <= ROUND_RESET;
      top_q         <= '0;
    end else begin
      if (cfg_we_i) round_limit_q <= cfg_wdata_i;
      if (op_i == OP_GROW && !st_o.oom) top_q <= (AW+1)'(top_x + blk_x);
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        a_q               <= '0;
        steps_q           <= '0;
        blk_q             <= blk_d;
        p_q               <= block_address_i;
        payload_address_o <= '0;
        status_o          <= 1'b0;
      end
      OP_WALK_EVAL: begin
        t_q <= rdata_q;
        if (st_o.fit) begin
          h_q <= a_q;
        end else if (!st_o.zero_tag) begin
          a_q     <= a_q + tclr_x;
          steps_q <= steps_q + (WW+1)'(1);
        end
      end
      OP_LD_TAG: t_q <= rdata_q;
      OP_GROW: begin
        if (st_o.oom) begin
          status_o <= 1'b1;
        end else begin
          h_q <= top_x;
          t_q <= blk_q;
        end
      end
      OP_MRK_HD:   payload_address_o <= ADDR_W'(h_q + EIGHT_X);
      OP_FREE_RD:  h_q <= p_x - EIGHT_X;
      OP_FREE_CLR: size_q <= tclr_x;
      OP_FREE_FT: begin
        fh_q <= h_q;
        ff_q <= h_q + size_q - EIGHT_X;
        nh_q <= h_q + size_q;
      end
      OP_RD_NXT: ph_q <= h_q - tclr_x;   // previous footer in rdata
      OP_RD_PHD: begin
        ntag_q <= rdata_q;               // next header in rdata
        nf_q   <= nh_q + tclr_x - EIGHT_X;
      end
      OP_MRG_PREV: begin
        if (has_prev && !rdata_q[0]) begin
          size_q <= size_q + XW'(rdata_q);
          fh_q   <= ph_q;
        end
      end
      OP_MRG_NEXT: begin
        if (has_next && !ntag_q[0]) begin
          size_q <= size_q + XW'(ntag_q);
          ff_q   <= nf_q;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/boundary_tag_first_fit_allocator.sv]
// First-fit heap allocator over a single-port tag memory (HEAP_BYTES/8 words of
// 18 bits, no clearing pass after reset). One request at a time: start is taken
// while busy is low, and the word comes back on done_o for exactly one cycle
// and cannot be held off. An allocate reads and checks each block header it
// walks, then takes the fit (split when large enough) or grows the heap, and
// marks the block; a free checks the address, then clears the block and merges
// it with free neighbours. Each step makes at most one access to the tag memory.
module boundary_tag_first_fit_allocator
  import btff_pkg::*;
#(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [REQ_W-1:0]   request_size_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  input  logic               cfg_we_i,
  input  logic [ROUND_W-1:0] cfg_wdata_i,
  output logic               done_o,
  output logic [ADDR_W-1:0]  payload_address_o,
  output logic               status_o
);

  op_e     op;
  status_t st;

  btff_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .st_i     (st),
    .op_o     (op),
    .busy     (busy),
    .done_o   (done_o)
  );

  btff_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .st_o              (st),
    .payload_address_o (payload_address_o),
    .status_o          (status_o)
  );

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o) else $error("controller did not return to idle");

  a_oom_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> payload_address_o == '0) else $error("address on oom");

endmodule

[verif/boundary_tag_first_fit_allocator_test.sv]
`timescale 1ns / 100ps

module boundary_tag_first_fit_allocator_test;
  import btff_pkg::*;

  localparam int TAG_WORDS = HEAP_BYTES_DEF / 8;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic              opc;
    logic [REQ_W-1:0]  size;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload;
    logic              oom;
  } reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode_i = OPC_ALLOC;
  logic [REQ_W-1:0]   request_size_i = '0;
  logic [ADDR_W-1:0]  block_address_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [ROUND_W-1:0] cfg_wdata_i = '0;
  logic               done_o;
  logic [ADDR_W-1:0]  payload_address_o;
  logic               status_o;

  boundary_tag_first_fit_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .opcode_i(opcode_i), .request_size_i(request_size_i),
    .block_address_i(block_address_i), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i), .done_o(done_o),
    .payload_address_o(payload_address_o), .status_o(status_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow heap
  logic [TAG_W-1:0]   tags [TAG_WORDS];
  int unsigned        heap_top;
  logic [ROUND_W-1:0] round_limit;

  request_t    pending [$];
  reply_t      replies_due [$];
  int unsigned live_blocks [$];
  int unsigned errors = 0;
  int unsigned gap = 0;
  int unsigned sent = 0;
  logic        took = 1'b0;
  logic        bursting = 1'b0;
  longint      cycles = 0;

  function automatic int unsigned tag_rd(input int unsigned a);
    return tags[(a >> 3) % TAG_WORDS];
  endfunction

  function automatic void tag_wr(input int unsigned a, input int unsigned v);
    tags[(a >> 3) % TAG_WORDS] = v[TAG_W-1:0];
  endfunction

  function automatic reply_t heap_alloc(input int unsigned req);
    int unsigned n, blk, a, steps, h, t;
    bit found;
    reply_t r;
    n = req;
    if (req <= round_limit) begin
      n = 1;
      while (n < req) n = n << 1;
    end
    blk = (n + 16 + 7) & ~32'd7;
    a = 0;
    steps = 0;
    found = 0;
    h = 0;
    while (a < heap_top && steps < TAG_WORDS) begin
      t = tag_rd(a);
      if (!t[0] && t >= blk) begin
        found = 1;
        h = a;
        break;
      end
      if ((t & ~32'd1) == 0) break;
      a += t & ~32'd1;
      steps++;
    end
    if (found) begin
      t = tag_rd(h);
      if (t - blk >= MIN_SPLIT) begin
        tag_wr(h + blk, t - blk);
        tag_wr(h + t - 8, t - blk);
        tag_wr(h, blk);
      end
    end else begin
      if (longint'(heap_top) + blk > HEAP_BYTES_DEF) begin
        r.payload = '0;
        r.oom = 1'b1;
        return r;
      end
      h = heap_top;
      heap_top += blk;
      tag_wr(h, blk);
    end
    t = tag_rd(h);
    tag_wr(h + t - 8, t | 1);
    tag_wr(h, t | 1);
    r.payload = ADDR_W'(h + 8);
    r.oom = 1'b0;
    return r;
  endfunction

  function automatic void heap_free(input int unsigned p);
    int unsigned h, sz, nh, ph, nf, fh, ff;
    bit has_prev, has_next;
    if (p < 8 || (p & 7) != 0 || p - 8 >= heap_top) return;
    h = p - 8;
    tag_wr(h, tag_rd(h) & ~32'd1);
    sz = tag_rd(h);
    tag_wr(h + sz - 8, sz);
    fh = h;
    ff = h + sz - 8;
    ph = 0;
    nf = 0;
    has_prev = h != 0;
    if (has_prev) ph = (h - 8) - (tag_rd(h - 8) & ~32'd1) + 8;
    nh = h + sz;
    has_next = nh < heap_top;
    if (has_next) nf = nh + (tag_rd(nh) & ~32'd1) - 8;
    if (has_prev && (tag_rd(ph) & 32'd1) == 0) begin
      sz += tag_rd(ph);
      fh = ph;
    end
    if (has_next && (tag_rd(nh) & 32'd1) == 0) begin
      sz += tag_rd(nh);
      ff = nf;
    end
    tag_wr(fh, sz);
    tag_wr(ff, sz);
  endfunction

  // acceptance, prediction and result check
  always @(posedge clk_i) begin
    reply_t want, r;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_ni) begin
      took <= start && !busy;
      if (cfg_we_i) round_limit = cfg_wdata_i;
      if (done_o) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: addr %0d status %0b",
                                     payload_address_o, status_o);
        end else begin
          want = replies_due.pop_front();
          if (want.payload !== payload_address_o || want.oom !== status_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected addr %0d status %0b, got addr %0d status %0b",
                       want.payload, want.oom, payload_address_o, status_o);
          end
        end
      end
      if (start && !busy) begin
        if (opcode_i == OPC_ALLOC) begin
          r = heap_alloc(request_size_i);
          if (!r.oom) live_blocks.push_back(r.payload);
        end else begin
          heap_free(block_address_i);
          r = '0;
        end
        replies_due.push_back(r);
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    request_t it;
    if (rst_ni && !(start && !took)) begin
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending.size() > 0) begin
        it = pending.pop_front();
        opcode_i <= it.opc;
        request_size_i <= it.size;
        block_address_i <= it.addr;
        start <= 1'b1;
        sent++;
        if (sent % 60 == 0) bursting = ~bursting;
        gap = bursting ? 0 : $urandom_range(0, 9);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_word(input logic opc, input int unsigned sz, input int unsigned a);
    request_t it;
    while (pending.size() != 0) @(posedge clk_i);
    it.opc = opc;
    it.size = REQ_W'(sz);
    it.addr = ADDR_W'(a);
    pending.push_back(it);
    @(posedge clk_i);
  endtask

  // wait until every word sent so far has been taken and answered
  task automatic settle();
    while (pending.size() != 0 || start || replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic free_live(input int unsigned idx);
    int unsigned p;
    // let outstanding allocations land in the live list first
    settle();
    if (live_blocks.size() == 0) return;
    idx = idx % live_blocks.size();
    p = live_blocks[idx];
    live_blocks.delete(idx);
    push_word(OPC_FREE, $urandom, p);
  endtask

  task automatic drain();
    while (pending.size() != 0 || start || replies_due.size() != 0 || busy)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_round(input int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ROUND_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned bad_address();
    int unsigned v, lo;
    v = $urandom_range(0, 65535);
    lo = (heap_top + 8 + 7) & ~32'd7;
    if (lo > 65535) lo = 65535;
    case ($urandom_range(0, 2))
      0: v = $urandom_range(0, 7);
      1: v = (v & ~32'd7) | $urandom_range(1, 7);
      default: v = $urandom_range(lo, 65535);
    endcase
    return v;
  endfunction

  task automatic random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38 && live_blocks.size() > 0) free_live($urandom);
    else if (pick < 45) begin
      // heap top must be current before an address above it is picked
      settle();
      push_word(OPC_FREE, $urandom, bad_address());
    end
    else if (pick < 80) push_word(OPC_ALLOC, $urandom_range(0, 300), $urandom);
    else if (pick < 95) push_word(OPC_ALLOC, $urandom_range(0, 4096), $urandom);
    else push_word(OPC_ALLOC, $urandom_range(0, 65535), $urandom);
  endtask

  initial begin
    heap_top = 0;
    round_limit = ROUND_RESET;
    foreach (tags[i]) tags[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: rounding edges, zero size, oom, rejected frees, splits, merges
    push_word(OPC_ALLOC, 0, 0);
    push_word(OPC_ALLOC, 1, 16'hFFFF);
    push_word(OPC_ALLOC, 512, 0);
    push_word(OPC_ALLOC, 513, 0);
    push_word(OPC_ALLOC, 100, 0);
    push_word(OPC_ALLOC, 200, 0);
    push_word(OPC_ALLOC, 65535, 0);
    push_word(OPC_FREE, 0, 0);
    push_word(OPC_FREE, 0, 4);
    push_word(OPC_FREE, 0, 13);
    push_word(OPC_FREE, 16'hFFFF, 16'hFFF8);
    free_live(1);
    free_live(1);
    free_live(2);
    push_word(OPC_ALLOC, 8, 0);
    push_word(OPC_ALLOC, 480, 0);
    free_live(0);
    push_word(OPC_ALLOC, 40000, 0);
    push_word(OPC_ALLOC, 30000, 0);
    drain();

    set_round(0);
    repeat (60) random_word();
    drain();
    set_round(65536);
    repeat (80) random_word();
    drain();
    set_round(1);
    repeat (60) random_word();
    drain();
    set_round(ROUND_RESET);
    repeat (2) begin
      repeat (40) random_word();
      drain();
    end
    set_round($urandom_range(0, 65536));
    repeat (80) random_word();
    drain();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
